FILE: hdl/dur_pkg.sv
// types and constants shared by the duration text parser
// no dependencies
`default_nettype none

package dur_pkg;

  // output field widths, fixed by the result format
  localparam int WHOLE_W = 49;
  localparam int US_W    = 20;
  localparam int TDATA_W = 72;

  // unit multipliers and arithmetic constants
  localparam int MULT_W  = 17;
  localparam int MPL_W   = 20;
  localparam int POW_W   = 40;
  localparam int CNT_W   = 5;
  localparam int DIVF_BITS = 17;
  localparam int DIVR_BITS = 20;

  localparam logic [MULT_W-1:0] MULT_SEC  = 17'd1;
  localparam logic [MULT_W-1:0] MULT_MIN  = 17'd60;
  localparam logic [MULT_W-1:0] MULT_HOUR = 17'd3600;
  localparam logic [MULT_W-1:0] MULT_DAY  = 17'd86400;
  localparam logic [MPL_W-1:0]  US_PER_SEC = 20'd1000000;
  localparam logic [US_W-1:0]   US_MAX     = 20'd1000000;

  // characters
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_H    = 8'h68;
  localparam logic [7:0] CH_D    = 8'h64;

  typedef enum logic [2:0] {
    PH_INT  = 3'b001,
    PH_FRAC = 3'b010,
    PH_UNIT = 3'b100
  } phase_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL_I = 7'b0000010,
    S_MUL_F = 7'b0000100,
    S_DIV_F = 7'b0001000,
    S_MUL_R = 7'b0010000,
    S_DIV_R = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  // powers of ten up to 10^12
  function automatic logic [POW_W-1:0] pow10(input logic [3:0] k);
    logic [POW_W-1:0] p;
    case (k)
      4'd0:    p = 40'd1;
      4'd1:    p = 40'd10;
      4'd2:    p = 40'd100;
      4'd3:    p = 40'd1000;
      4'd4:    p = 40'd10000;
      4'd5:    p = 40'd100000;
      4'd6:    p = 40'd1000000;
      4'd7:    p = 40'd10000000;
      4'd8:    p = 40'd100000000;
      4'd9:    p = 40'd1000000000;
      4'd10:   p = 40'd10000000000;
      4'd11:   p = 40'd100000000000;
      4'd12:   p = 40'd1000000000000;
      default: p = 40'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/duration_string_parser.sv
// duration text parser: characters in, whole seconds and microseconds out
// depends on dur_pkg
`default_nettype none

// Usage
//  s_* channel: one text character per transfer, s_tlast on its final character.
//  m_* channel: one result transfer per text, issued after the last character.
//  Characters are taken one per cycle while the block is idle. After the last
//  character the block runs a small sequencer over one shared add/subtract
//  unit: two shift-add multiplies by the unit multiplier, each stepping
//  through the multiplier bits, a 17-step restoring division by 10^k, a
//  shift-add multiply by 10^6 and a 20-step division; an invalid text needs
//  no arithmetic and its result goes straight to the output register, or is
//  held while that register is still occupied.
//  s_tready is low while the arithmetic runs.
//  The result sits in an output register, so the next text can stream in
//  while a result is still waiting; if a new result finishes while the old one
//  is still held, the block waits with s_tready low until the receiver takes it.
//  Reset (rst, synchronous) returns the parser to the start of a text and
//  drops any pending result.
module duration_string_parser #(
  parameter int MAX_FRAC_DIGITS = 9,
  parameter int INT_BITS        = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,   // [7:0] character
  input  wire logic                         s_tlast,   // last character of the text
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [dur_pkg::TDATA_W-1:0]       m_tdata,   // [48:0] whole_seconds,
                                                       // [68:49] microseconds, [71:69] 0
  output logic                              m_tuser    // [0] invalid
);
  import dur_pkg::*;

  // fraction value holds up to MAX_FRAC_DIGITS decimal digits
  localparam int FRAC_W = (MAX_FRAC_DIGITS * 3322) / 1000 + 1;
  localparam int FCNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  // accumulator covers r*10^6 + 10^k/2 and the 49-bit whole product
  localparam int ACC_W  = (FRAC_W + 20 > WHOLE_W) ? FRAC_W + 20 : WHOLE_W;
  localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(MAX_FRAC_DIGITS);

  state_t state;

  // parse state
  phase_t              phase, phase_next;
  logic [INT_BITS-1:0] ival, ival_next;
  logic                seen, seen_next;
  logic [FRAC_W-1:0]   fval, fval_next;
  logic [FCNT_W-1:0]   fcnt, fcnt_next;
  logic [MULT_W-1:0]   mult, mult_next;
  logic                err, err_next;

  // shared arithmetic
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    opnd;
  logic [MPL_W-1:0]    mplier;
  logic [ACC_W-1:0]    pw;
  logic [US_W-1:0]     quot;
  logic [CNT_W-1:0]    cnt;
  logic [ACC_W-1:0]    sum;
  logic [ACC_W:0]      diff;
  logic                ge;
  logic [US_W-1:0]     quot_new;

  // finished result, held while the output register is busy
  logic [WHOLE_W-1:0]  res_whole;
  logic [US_W-1:0]     res_us;
  logic                res_inv;

  // output register
  logic [WHOLE_W-1:0]  out_whole;
  logic [US_W-1:0]     out_us;

  logic                s_acc;
  logic                out_free;
  logic                bad_next;
  logic                fin;
  logic [WHOLE_W-1:0]  fin_whole;
  logic [US_W-1:0]     fin_us;
  logic                fin_inv;

  // character decode
  logic                   is_digit;
  logic [3:0]             dig;
  logic                   is_unit;
  logic [MULT_W-1:0]      unit_mult;
  logic [INT_BITS+3:0]    ival_cand;
  logic [FRAC_W+3:0]      fval_cand;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign m_tdata = {(TDATA_W - WHOLE_W - US_W)'(0), out_us, out_whole};

  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign dig      = is_digit ? s_tdata[3:0] : 4'd0;

  always_comb begin
    is_unit   = 1'b1;
    unit_mult = MULT_SEC;
    case (s_tdata)
      CH_S:    unit_mult = MULT_SEC;
      CH_M:    unit_mult = MULT_MIN;
      CH_H:    unit_mult = MULT_HOUR;
      CH_D:    unit_mult = MULT_DAY;
      default: is_unit = 1'b0;
    endcase
  end

  // value*10 + digit as shift-add; upper bits flag integer overflow
  assign ival_cand = ((INT_BITS+4)'(ival) << 3) + ((INT_BITS+4)'(ival) << 1)
                   + (INT_BITS+4)'(dig);
  assign fval_cand = ((FRAC_W+4)'(fval) << 3) + ((FRAC_W+4)'(fval) << 1)
                   + (FRAC_W+4)'(dig);

  always_comb begin
    phase_next = phase;
    ival_next  = ival;
    seen_next  = seen;
    fval_next  = fval;
    fcnt_next  = fcnt;
    mult_next  = mult;
    err_next   = err;
    unique case (phase)
      PH_INT: begin
        if (is_digit) begin
          if (ival_cand[INT_BITS+3:INT_BITS] != 4'd0) begin
            err_next = 1'b1;
          end else begin
            ival_next = ival_cand[INT_BITS-1:0];
          end
          seen_next = 1'b1;
        end else if (s_tdata == CH_DOT) begin
          phase_next = PH_FRAC;
        end else if (is_unit) begin
          mult_next  = unit_mult;
          phase_next = PH_UNIT;
        end else begin
          err_next = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          // extra fraction digits are dropped
          if (fcnt < FCNT_MAX) begin
            fval_next = fval_cand[FRAC_W-1:0];
            fcnt_next = fcnt + 1'b1;
          end
        end else if (is_unit) begin
          mult_next  = unit_mult;
          phase_next = PH_UNIT;
        end else begin
          err_next = 1'b1;
        end
      end
      PH_UNIT: begin
        err_next = 1'b1;
      end
      default: begin
        err_next = 1'b1;
      end
    endcase
  end

  // no digits at all, or an error along the way
  assign bad_next = err_next || (!seen_next && (fcnt_next == '0));

  // the shared add/subtract unit
  assign sum      = acc + opnd;
  assign diff     = {1'b0, acc} - {1'b0, opnd};
  assign ge       = !diff[ACC_W];
  assign quot_new = {quot[US_W-2:0], ge};

  always_comb begin
    fin       = 1'b0;
    fin_whole = res_whole;
    fin_us    = res_us;
    fin_inv   = res_inv;
    unique case (state)
      S_IDLE: begin
        if (s_acc && s_tlast && bad_next) begin
          fin       = 1'b1;
          fin_whole = '0;
          fin_us    = '0;
          fin_inv   = 1'b1;
        end
      end
      S_DIV_R: begin
        if (cnt == '0) begin
          fin       = 1'b1;
          fin_whole = res_whole;
          fin_us    = quot_new;
          fin_inv   = 1'b0;
        end
      end
      S_WAIT: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_INT;
      ival     <= '0;
      seen     <= 1'b0;
      fval     <= '0;
      fcnt     <= '0;
      mult     <= MULT_SEC;
      err      <= 1'b0;
      m_tvalid <= 1'b0;
      m_tuser  <= 1'b0;
      res_inv  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            phase <= phase_next;
            ival  <= ival_next;
            seen  <= seen_next;
            fval  <= fval_next;
            fcnt  <= fcnt_next;
            mult  <= mult_next;
            err   <= err_next;
            if (s_tlast) begin
              if (bad_next) begin
                phase <= PH_INT;
                ival  <= '0;
                seen  <= 1'b0;
                fval  <= '0;
                fcnt  <= '0;
                mult  <= MULT_SEC;
                err   <= 1'b0;
              end else begin
                // start whole = integer * multiplier
                acc    <= '0;
                opnd   <= ACC_W'(ival_next);
                mplier <= MPL_W'(mult_next);
                pw     <= ACC_W'(pow10(4'(fcnt_next)));
                state  <= S_MUL_I;
              end
            end
          end
        end
        S_MUL_I: begin
          if (mplier == '0) begin
            res_whole <= acc[WHOLE_W-1:0];
            acc       <= '0;
            opnd      <= ACC_W'(fval);
            mplier    <= MPL_W'(mult);
            state     <= S_MUL_F;
          end else begin
            if (mplier[0]) begin
              acc <= sum;
            end
            opnd   <= opnd << 1;
            mplier <= mplier >> 1;
          end
        end
        S_MUL_F: begin
          if (mplier == '0) begin
            // acc holds fraction * multiplier, divide it by 10^k
            opnd  <= pw << (DIVF_BITS - 1);
            cnt   <= CNT_W'(DIVF_BITS - 1);
            quot  <= '0;
            state <= S_DIV_F;
          end else begin
            if (mplier[0]) begin
              acc <= sum;
            end
            opnd   <= opnd << 1;
            mplier <= mplier >> 1;
          end
        end
        S_DIV_F: begin
          quot <= quot_new;
          opnd <= opnd >> 1;
          cnt  <= cnt - 1'b1;
          if (ge) begin
            acc <= diff[ACC_W-1:0];
          end
          if (cnt == '0) begin
            res_whole <= res_whole + WHOLE_W'(quot_new);
            // remainder * 10^6 plus half of 10^k, for round half up
            opnd   <= ge ? diff[ACC_W-1:0] : acc;
            acc    <= pw >> 1;
            mplier <= US_PER_SEC;
            state  <= S_MUL_R;
          end
        end
        S_MUL_R: begin
          if (mplier == '0) begin
            opnd  <= pw << (DIVR_BITS - 1);
            cnt   <= CNT_W'(DIVR_BITS - 1);
            quot  <= '0;
            state <= S_DIV_R;
          end else begin
            if (mplier[0]) begin
              acc <= sum;
            end
            opnd   <= opnd << 1;
            mplier <= mplier >> 1;
          end
        end
        S_DIV_R: begin
          quot <= quot_new;
          opnd <= opnd >> 1;
          cnt  <= cnt - 1'b1;
          if (ge) begin
            acc <= diff[ACC_W-1:0];
          end
          if (cnt == '0) begin
            // text done, back to the start of the next one
            phase <= PH_INT;
            ival  <= '0;
            seen  <= 1'b0;
            fval  <= '0;
            fcnt  <= '0;
            mult  <= MULT_SEC;
            err   <= 1'b0;
          end
        end
        S_WAIT: begin
          state <= S_WAIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // hand a finished result to the output register or hold it
      if (fin) begin
        if (out_free) begin
          out_whole <= fin_whole;
          out_us    <= fin_us;
          m_tuser   <= fin_inv;
          m_tvalid  <= 1'b1;
          state     <= S_IDLE;
        end else begin
          res_whole <= fin_whole;
          res_us    <= fin_us;
          res_inv   <= fin_inv;
          state     <= S_WAIT;
        end
      end
    end
  end

  // an invalid result carries zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (out_whole == '0) && (out_us == '0))
    else $error("invalid result with nonzero fields");

  // rounded microseconds never pass one second
  a_us_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_us <= US_MAX)
    else $error("microseconds out of range");

  // the block only waits while the output register is occupied
  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |-> m_tvalid)
    else $error("waiting with a free output register");

  // kept fraction digits stay within the limit
  a_fcnt_max: assert property (@(posedge clk) disable iff (rst)
    fcnt <= FCNT_MAX)
    else $error("fraction digit count over limit");

  // a parse error stays until the text ends
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err && !(s_acc && s_tlast) && state == S_IDLE |=> err)
    else $error("parse error dropped inside a text");

endmodule

`default_nettype wire
